// ===== sv/recursive_mutex_fifo_handoff_assert.svh =====
// assertion macros for the recursive mutex block
// used by the top level; expects clk and rst_n in scope
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_ASSERT_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_ASSERT_SVH

// same-cycle implication
`define RMFH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmfh assertion failed");

// next-cycle implication
`define RMFH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmfh assertion failed");

`endif

// ===== sv/rmfh_pkg.sv =====
// shared types and constants for the recursive mutex block
// no dependencies
package rmfh_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int USED_W      = $clog2(MAX_WAITERS + 1);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FREE = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;
    } sts_t;

endpackage

// ===== sv/rmfh_ctrl.sv =====
// controller state machine for the recursive mutex block
// depends on rmfh_pkg
module rmfh_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rmfh_pkg::sts_t  sts,
    output rmfh_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for room in the output register
                if (!sts.out_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/rmfh_dpath.sv =====
// datapath for the recursive mutex block: owner, count, waiter queue, result register
// depends on rmfh_pkg
module rmfh_dpath
(
    input  logic            clk,
    input  logic            rst_n,
    input  rmfh_pkg::cmd_t  cmd,
    output rmfh_pkg::sts_t  sts,
    input  logic            opcode,
    input  logic [7:0]      thread_id,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            granted,
    output logic            sleep_request,
    output logic            wake_valid,
    output logic [7:0]      wake_thread,
    output logic [7:0]      owner_now,
    output logic [15:0]     hold_count,
    output logic [1:0]      status
);

    logic                        req_op_reg;
    logic [7:0]                  req_tid_reg;
    logic [7:0]                  owner_reg;
    logic [7:0]                  owner_next;
    logic [15:0]                 count_reg;
    logic [15:0]                 count_next;
    logic [rmfh_pkg::PTR_W-1:0]  head_reg;
    logic [rmfh_pkg::PTR_W-1:0]  head_next;
    logic [rmfh_pkg::PTR_W-1:0]  tail_reg;
    logic [rmfh_pkg::PTR_W-1:0]  tail_next;
    logic [rmfh_pkg::USED_W-1:0] used_reg;
    logic [rmfh_pkg::USED_W-1:0] used_next;
    logic [7:0]                  head_data_reg;
    logic [7:0]                  mem [rmfh_pkg::MAX_WAITERS];
    logic                        enqueue;
    logic                        out_valid_reg;
    logic                        load;

    logic                        granted_next;
    logic                        sleep_next;
    logic                        wake_next;
    logic [7:0]                  wake_tid_next;
    rmfh_pkg::status_t           status_next;

    logic                        granted_reg;
    logic                        sleep_reg;
    logic                        wake_reg;
    logic [7:0]                  wake_tid_reg;
    logic [7:0]                  owner_out_reg;
    logic [15:0]                 count_out_reg;
    logic [1:0]                  status_reg;

    function automatic logic [rmfh_pkg::PTR_W-1:0] next_slot(
        input logic [rmfh_pkg::PTR_W-1:0] p
    );
        if (p == rmfh_pkg::PTR_W'(rmfh_pkg::MAX_WAITERS - 1))
            return '0;
        else
            return p + rmfh_pkg::PTR_W'(1);
    endfunction

    assign sts.out_blocked = out_valid_reg && out_stall;
    assign load            = cmd.exec;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg  <= opcode;
            req_tid_reg <= thread_id;
        end
    end

    // waiter queue storage, head entry registered in head_data_reg ahead of its use
    always_ff @(posedge clk)
    begin
        if (load && enqueue)
            mem[tail_reg] <= req_tid_reg;
        head_data_reg <= mem[head_reg];
    end

    always_comb
    begin
        owner_next    = owner_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        enqueue       = 1'b0;
        granted_next  = 1'b0;
        sleep_next    = 1'b0;
        wake_next     = 1'b0;
        wake_tid_next = 8'd0;
        status_next   = rmfh_pkg::ST_OK;
        if (req_op_reg == rmfh_pkg::OP_LOCK)
        begin
            if (req_tid_reg == 8'd0)
            begin
                // reserved id, ignored
            end
            else if (count_reg == 16'd0 || owner_reg == req_tid_reg)
            begin
                if (count_reg == rmfh_pkg::COUNT_MAX)
                    status_next = rmfh_pkg::ST_SAT;
                else
                begin
                    owner_next   = req_tid_reg;
                    count_next   = count_reg + 16'd1;
                    granted_next = 1'b1;
                end
            end
            else if (used_reg == rmfh_pkg::USED_W'(rmfh_pkg::MAX_WAITERS))
                status_next = rmfh_pkg::ST_FULL;
            else
            begin
                enqueue    = 1'b1;
                tail_next  = next_slot(tail_reg);
                used_next  = used_reg + rmfh_pkg::USED_W'(1);
                sleep_next = 1'b1;
            end
        end
        else
        begin
            if (count_reg == 16'd0)
                status_next = rmfh_pkg::ST_FREE;
            else if (count_reg != 16'd1)
                count_next = count_reg - 16'd1;
            else if (used_reg != '0)
            begin
                // hand off to the oldest waiter
                owner_next    = head_data_reg;
                count_next    = 16'd1;
                head_next     = next_slot(head_reg);
                used_next     = used_reg - rmfh_pkg::USED_W'(1);
                wake_next     = 1'b1;
                wake_tid_next = head_data_reg;
            end
            else
            begin
                owner_next = 8'd0;
                count_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg     <= 8'd0;
            count_reg     <= 16'd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                owner_reg <= owner_next;
                count_reg <= count_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                used_reg  <= used_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            granted_reg   <= granted_next;
            sleep_reg     <= sleep_next;
            wake_reg      <= wake_next;
            wake_tid_reg  <= wake_tid_next;
            owner_out_reg <= owner_next;
            count_out_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign sleep_request = sleep_reg;
    assign wake_valid    = wake_reg;
    assign wake_thread   = wake_tid_reg;
    assign owner_now     = owner_out_reg;
    assign hold_count    = count_out_reg;
    assign status        = status_reg;

endmodule

// ===== sv/recursive_mutex_fifo_handoff.sv =====
// recursive mutex with a bounded fifo of waiting threads
// input channel: in_valid/in_stall with opcode (0 lock, 1 unlock) and thread_id
// output channel: out_valid/out_stall with one result transaction per request:
//   granted, sleep_request, wake_valid, wake_thread, owner_now, hold_count, status
// each request is first captured (while the head of the waiter queue is read from its
//   memory), then executed, updating owner, count and queue pointers
// out_valid rises once the captured request has executed, which waits while the output
//   register is blocked; no new request is taken until the previous one has executed
// a new request is taken while the previous result still waits in the output
//   register; when the receiver stalls, the next result waits in the execute
//   state and in_stall stays high until it can be written
// reset clears owner, count, queue pointers and out_valid at once; the queue
//   memory is not cleared, only entries written since are ever read
// status: 0 ok, 1 waiter queue full, 2 unlock while free, 3 count saturated
// depends on rmfh_pkg, rmfh_ctrl, rmfh_dpath and the assertion macro header
`include "recursive_mutex_fifo_handoff_assert.svh"

module recursive_mutex_fifo_handoff
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  thread_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        granted,
    output logic        sleep_request,
    output logic        wake_valid,
    output logic [7:0]  wake_thread,
    output logic [7:0]  owner_now,
    output logic [15:0] hold_count,
    output logic [1:0]  status
);

    rmfh_pkg::cmd_t cmd;
    rmfh_pkg::sts_t sts;

    rmfh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmfh_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .thread_id     (thread_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .sleep_request (sleep_request),
        .wake_valid    (wake_valid),
        .wake_thread   (wake_thread),
        .owner_now     (owner_now),
        .hold_count    (hold_count),
        .status        (status)
    );

    // one request in flight at a time
    `RMFH_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
    // a handoff leaves the woken thread as owner with a count of one
    `RMFH_ASSERT_NOW(a_wake_owner, out_valid && wake_valid,
        owner_now == wake_thread && hold_count == 16'd1 && wake_thread != 8'd0)
    // a grant always leaves a held mutex with ok status
    `RMFH_ASSERT_NOW(a_grant_held, out_valid && granted,
        owner_now != 8'd0 && hold_count != 16'd0 && status == rmfh_pkg::ST_OK)
    // no result is written over one that the receiver still stalls
    `RMFH_ASSERT_NOW(a_no_overwrite, cmd.exec, !(out_valid && out_stall))

endmodule
